FILE: hw/rtl/rtbd_pkg.sv
// rtbd_pkg: shared constants, the internal number type and its helper functions
// for the three-body derivative pipeline; depends on nothing
package rtbd_pkg;

  localparam int WORD_BITS_DEF = 40;
  localparam int FRAC_BITS_DEF = 32;
  localparam int MASS_BITS     = 32;
  localparam logic [MASS_BITS-1:0] MASS_RESET = 32'd12898;

  localparam int MANT_BITS  = 62;
  localparam int WIDE_BITS  = 64;
  localparam int LZ_BITS    = 7;
  localparam int EXP_BITS   = 12;

  localparam int LAT_ADD    = 3;
  localparam int LAT_MUL    = 3;
  localparam int ROOT_STEPS = 62;
  localparam int QUO_STEPS  = 63;
  localparam int LAT_SQRT   = ROOT_STEPS + 1;
  localparam int LAT_DIV    = QUO_STEPS + 1;

  typedef struct packed {
    logic                       neg;
    logic [MANT_BITS-1:0]       m;
    logic signed [EXP_BITS-1:0] e;
  } xf_t;

  localparam int XF_BITS = $bits(xf_t);

  // leading one moved to bit 61, low bits dropped on a right shift
  function automatic xf_t xf_norm(input logic neg, input logic [WIDE_BITS-1:0] mag,
                                  input logic signed [EXP_BITS-1:0] e);
    xf_t                  r;
    logic [LZ_BITS-1:0]   lz;
    logic [WIDE_BITS-1:0] sh;
    lz = LZ_BITS'(WIDE_BITS);
    for (int i = 0; i < WIDE_BITS; i++) begin
      if (mag[i]) lz = LZ_BITS'(WIDE_BITS - 1 - i);
    end
    if (lz < LZ_BITS'(2)) sh = mag >> (LZ_BITS'(2) - lz);
    else sh = mag << (lz - LZ_BITS'(2));
    r.neg = neg;
    r.m   = sh[MANT_BITS-1:0];
    r.e   = e + EXP_BITS'(2) - EXP_BITS'(lz);
    if (mag == '0) r = '0;
    return r;
  endfunction

  function automatic xf_t xf_neg(input xf_t a);
    xf_t r;
    r = a;
    if (a.m != '0) r.neg = !a.neg;
    return r;
  endfunction

  function automatic xf_t xf_dbl(input xf_t a);
    xf_t r;
    r = a;
    if (a.m != '0) r.e = a.e + EXP_BITS'(1);
    return r;
  endfunction

endpackage

FILE: hw/rtl/rtbd_if.sv
// rtbd_in_if / rtbd_out_if: valid-ready channels for state and derivative
// transactions; depend on rtbd_pkg
interface rtbd_in_if #(
  parameter int WORD_BITS = rtbd_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] pos_x;
  logic signed [WORD_BITS-1:0] pos_y;
  logic signed [WORD_BITS-1:0] pos_z;
  logic signed [WORD_BITS-1:0] vel_x;
  logic signed [WORD_BITS-1:0] vel_y;
  logic signed [WORD_BITS-1:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface rtbd_out_if #(
  parameter int WORD_BITS = rtbd_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] rate_x;
  logic signed [WORD_BITS-1:0] rate_y;
  logic signed [WORD_BITS-1:0] rate_z;
  logic signed [WORD_BITS-1:0] acc_x;
  logic signed [WORD_BITS-1:0] acc_y;
  logic signed [WORD_BITS-1:0] acc_z;
  logic                        saturated;
  logic                        singular;

  modport source (output valid, rate_x, rate_y, rate_z, acc_x, acc_y, acc_z, saturated,
                  singular, input ready);
  modport sink   (input valid, rate_x, rate_y, rate_z, acc_x, acc_y, acc_z, saturated,
                  singular, output ready);
endinterface

FILE: hw/rtl/rtbd_delay.sv
// rtbd_delay: enabled shift line that keeps side data level with the units
// depends on nothing
module rtbd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];
endmodule

FILE: hw/rtl/rtbd_fadd.sv
// rtbd_fadd: three-stage adder for the internal number type (align, add, normalise)
// depends on rtbd_pkg
module rtbd_fadd (
  input  logic           clk,
  input  logic           en,
  input  rtbd_pkg::xf_t  a,
  input  rtbd_pkg::xf_t  b,
  output rtbd_pkg::xf_t  y
);
  localparam int MB = rtbd_pkg::MANT_BITS;
  localparam int EB = rtbd_pkg::EXP_BITS;
  localparam int WB = rtbd_pkg::WIDE_BITS;

  rtbd_pkg::xf_t        big, sml, big_r, y_r;
  logic signed [EB:0]   dexp;
  logic [MB-1:0]        bm, bm_r;
  logic                 sub_r, sneg_r;
  logic [WB-1:0]        sum, sum_r;
  logic                 neg, neg_r;
  logic signed [EB-1:0] e_r;

  always_comb begin
    big = a;
    sml = b;
    if (a.m == '0) begin
      big = b;
      sml = '0;
    end else if (b.m == '0) begin
      sml = '0;
    end else if ($signed(b.e) > $signed(a.e)) begin
      big = b;
      sml = a;
    end
    dexp = $signed({big.e[EB-1], big.e}) - $signed({sml.e[EB-1], sml.e});
    if (dexp > $signed((EB+1)'(WB - 1))) bm = '0;
    else bm = sml.m >> dexp[5:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big_r  <= big;
      bm_r   <= bm;
      sub_r  <= big.neg ^ sml.neg;
      sneg_r <= sml.neg;
    end
  end

  always_comb begin
    if (!sub_r) begin
      sum = WB'(big_r.m) + WB'(bm_r);
      neg = big_r.neg;
    end else if (big_r.m >= bm_r) begin
      sum = WB'(big_r.m - bm_r);
      neg = big_r.neg;
    end else begin
      sum = WB'(bm_r - big_r.m);
      neg = sneg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum;
      neg_r <= neg;
      e_r   <= big_r.e;
      y_r   <= rtbd_pkg::xf_norm(neg_r, sum_r, e_r);
    end
  end

  assign y = y_r;
endmodule

FILE: hw/rtl/rtbd_fmul.sv
// rtbd_fmul: three-stage multiplier for the internal number type, built from
// four 31x31 partial products; depends on rtbd_pkg
module rtbd_fmul (
  input  logic           clk,
  input  logic           en,
  input  rtbd_pkg::xf_t  a,
  input  rtbd_pkg::xf_t  b,
  output rtbd_pkg::xf_t  y
);
  localparam int MB   = rtbd_pkg::MANT_BITS;
  localparam int EB   = rtbd_pkg::EXP_BITS;
  localparam int HALF = MB / 2;
  localparam int PB   = 2 * MB;

  logic [MB-1:0]        hh_r, hl_r, lh_r, ll_r;
  logic [MB:0]          mid_r;
  logic [PB-1:0]        base_r, prod;
  logic [MB-1:0]        top;
  logic                 n1_r, n2_r, z1_r, z2_r;
  logic signed [EB-1:0] e1_r, e2_r;
  rtbd_pkg::xf_t        y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= MB'(a.m[MB-1:HALF]) * MB'(b.m[MB-1:HALF]);
      hl_r <= MB'(a.m[MB-1:HALF]) * MB'(b.m[HALF-1:0]);
      lh_r <= MB'(a.m[HALF-1:0]) * MB'(b.m[MB-1:HALF]);
      ll_r <= MB'(a.m[HALF-1:0]) * MB'(b.m[HALF-1:0]);
      n1_r <= a.neg ^ b.neg;
      z1_r <= (a.m == '0) || (b.m == '0);
      e1_r <= a.e + b.e + EB'(MB);
      mid_r  <= (MB+1)'(hl_r) + (MB+1)'(lh_r);
      base_r <= {hh_r, ll_r};
      n2_r   <= n1_r;
      z2_r   <= z1_r;
      e2_r   <= e1_r;
    end
  end

  always_comb begin
    prod = base_r + {(PB-MB-1-HALF)'(0), mid_r, HALF'(0)};
    top  = prod[PB-1:MB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (z2_r) begin
        y_r <= '0;
      end else if (top[MB-1]) begin
        y_r <= '{neg: n2_r, m: top, e: e2_r};
      end else begin
        y_r <= '{neg: n2_r, m: {top[MB-2:0], 1'b0}, e: e2_r - EB'(1)};
      end
    end
  end

  assign y = y_r;
endmodule

FILE: hw/rtl/rtbd_fsqrt.sv
// rtbd_fsqrt: square root of the internal number type, one result bit per
// pipeline stage plus a normalise stage; depends on rtbd_pkg
module rtbd_fsqrt (
  input  logic           clk,
  input  logic           en,
  input  rtbd_pkg::xf_t  a,
  output rtbd_pkg::xf_t  y
);
  localparam int MB    = rtbd_pkg::MANT_BITS;
  localparam int EB    = rtbd_pkg::EXP_BITS;
  localparam int WB    = rtbd_pkg::WIDE_BITS;
  localparam int STEPS = rtbd_pkg::ROOT_STEPS;
  localparam int SQ_SH = MB - 2;

  logic [WB-1:0]        m0;
  logic signed [EB-1:0] ex, e2;

  logic [WB-1:0]        rem_r  [STEPS];
  logic [MB-1:0]        root_r [STEPS];
  logic [WB-1:0]        m_r    [STEPS];
  logic signed [EB-1:0] e_r    [STEPS];
  logic                 z_r    [STEPS];
  rtbd_pkg::xf_t        y_r;

  always_comb begin
    if (a.e[0]) begin
      m0 = {1'b0, a.m, 1'b0};
      ex = a.e - EB'(1) - EB'(SQ_SH);
    end else begin
      m0 = {2'b0, a.m};
      ex = a.e - EB'(SQ_SH);
    end
    e2 = ex >>> 1;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int PI = 2 * (STEPS - 1 - k) - SQ_SH;
    logic [WB-1:0]        rem_in, m_in;
    logic [MB-1:0]        root_in;
    logic signed [EB-1:0] e_in;
    logic                 z_in, ge;
    logic [1:0]           pair;
    logic [WB+1:0]        remx, trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign m_in    = m0;
      assign e_in    = e2;
      assign z_in    = (a.m == '0);
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign m_in    = m_r[k-1];
      assign e_in    = e_r[k-1];
      assign z_in    = z_r[k-1];
    end

    if (PI >= 0) begin : g_pair
      assign pair = m_in[PI+1:PI];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign remx  = {rem_in, pair};
    assign trial = (WB+2)'({root_in, 2'b01});
    assign ge    = remx >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? WB'(remx - trial) : WB'(remx);
        root_r[k] <= {root_in[MB-2:0], ge};
        m_r[k]    <= m_in;
        e_r[k]    <= e_in;
        z_r[k]    <= z_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_r[STEPS-1]) begin
        y_r <= '0;
      end else if (root_r[STEPS-1][MB-1]) begin
        y_r <= '{neg: 1'b0, m: root_r[STEPS-1], e: e_r[STEPS-1]};
      end else begin
        y_r <= '{neg: 1'b0, m: {root_r[STEPS-1][MB-2:0], 1'b0},
                 e: e_r[STEPS-1] - EB'(1)};
      end
    end
  end

  assign y = y_r;
endmodule

FILE: hw/rtl/rtbd_fdiv.sv
// rtbd_fdiv: restoring divider for the internal number type, one quotient bit
// per pipeline stage plus a normalise stage; depends on rtbd_pkg
module rtbd_fdiv (
  input  logic           clk,
  input  logic           en,
  input  rtbd_pkg::xf_t  a,
  input  rtbd_pkg::xf_t  b,
  output rtbd_pkg::xf_t  y
);
  localparam int MB    = rtbd_pkg::MANT_BITS;
  localparam int EB    = rtbd_pkg::EXP_BITS;
  localparam int WB    = rtbd_pkg::WIDE_BITS;
  localparam int STEPS = rtbd_pkg::QUO_STEPS;

  logic [WB-1:0]        r_r [STEPS];
  logic [STEPS-1:0]     q_r [STEPS];
  logic [MB-1:0]        d_r [STEPS];
  logic signed [EB-1:0] e_r [STEPS];
  logic                 n_r [STEPS];
  logic                 z_r [STEPS];
  logic [STEPS-1:0]     qf;
  rtbd_pkg::xf_t        y_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [WB-1:0]        r_in, r_sub;
    logic [STEPS-1:0]     q_in;
    logic [MB-1:0]        d_in;
    logic signed [EB-1:0] e_in;
    logic                 n_in, z_in, ge;

    if (k == 0) begin : g_first
      assign r_in = WB'(a.m);
      assign q_in = '0;
      assign d_in = b.m;
      assign e_in = a.e - b.e - EB'(MB);
      assign n_in = a.neg ^ b.neg;
      assign z_in = (a.m == '0) || (b.m == '0);
    end else begin : g_next
      assign r_in = r_r[k-1];
      assign q_in = q_r[k-1];
      assign d_in = d_r[k-1];
      assign e_in = e_r[k-1];
      assign n_in = n_r[k-1];
      assign z_in = z_r[k-1];
    end

    assign ge    = r_in >= WB'(d_in);
    assign r_sub = ge ? r_in - WB'(d_in) : r_in;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= r_sub << 1;
        q_r[k] <= {q_in[STEPS-2:0], ge};
        d_r[k] <= d_in;
        e_r[k] <= e_in;
        n_r[k] <= n_in;
        z_r[k] <= z_in;
      end
    end
  end

  assign qf = q_r[STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_r[STEPS-1]) begin
        y_r <= '0;
      end else if (qf[STEPS-1]) begin
        y_r <= '{neg: n_r[STEPS-1], m: qf[STEPS-1:1], e: e_r[STEPS-1] + EB'(1)};
      end else begin
        y_r <= '{neg: n_r[STEPS-1], m: qf[MB-1:0], e: e_r[STEPS-1]};
      end
    end
  end

  assign y = y_r;
endmodule

FILE: hw/rtl/restricted_three_body_derivative.sv
// Circular restricted three-body derivative pipeline: takes a rotating-frame
// state transaction and returns its time derivative. One transaction enters per
// clock unless the pipeline holds; a result leaves the output register after the
// chain of units: one input conversion stage, seven adder or multiplier passes of
// three stages, the 62-stage square root (one root bit per stage) and the 63-stage
// divider (one quotient bit per stage), each with a normalise stage, and the output
// register. The whole pipeline holds while the output register is full and not
// taken. Velocities pass through; accelerations are truncated toward zero and
// saturated, with flags for clipping and for a zero distance to either primary.
// mass_ratio resets to 12898 and is written through cfg_wr_en / cfg_wr_data.
// depends on rtbd_pkg, rtbd_if, rtbd_delay, rtbd_fadd, rtbd_fmul, rtbd_fsqrt, rtbd_fdiv
module restricted_three_body_derivative #(
  parameter int WORD_BITS = rtbd_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rtbd_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rtbd_in_if.sink                        in_item,
  rtbd_out_if.source                     out_item,
  input  logic                           cfg_wr_en,
  input  logic [rtbd_pkg::MASS_BITS-1:0] cfg_wr_data
);
  localparam int EB  = rtbd_pkg::EXP_BITS;
  localparam int WB  = rtbd_pkg::WIDE_BITS;
  localparam int XB  = rtbd_pkg::XF_BITS;
  localparam int MSB = rtbd_pkg::MASS_BITS;
  localparam int LA  = rtbd_pkg::LAT_ADD;
  localparam int LM  = rtbd_pkg::LAT_MUL;
  localparam int T0  = 1;
  localparam int T1  = T0 + LA;
  localparam int T2  = T1 + LM;
  localparam int T3  = T2 + LA;
  localparam int T4  = T3 + rtbd_pkg::LAT_SQRT;
  localparam int T5  = T4 + LM;
  localparam int T6  = T5 + rtbd_pkg::LAT_DIV;
  localparam int T7  = T6 + LM;
  localparam int T8  = T7 + LA;
  localparam int T9  = T8 + LA;
  localparam int SH_CLIP = 3;
  localparam logic signed [EB-1:0] E_IN   = EB'(-FRAC_BITS);
  localparam logic signed [EB-1:0] E_MASS = EB'(-MSB);
  localparam logic [WORD_BITS-1:0] ACC_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] ACC_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic rtbd_pkg::xf_t to_xf(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] mag;
    mag = v[WORD_BITS-1] ? -v : v;
    return rtbd_pkg::xf_norm(v[WORD_BITS-1], WB'(mag), E_IN);
  endfunction

  // {clip, word}
  function automatic logic [WORD_BITS:0] xf_out(input rtbd_pkg::xf_t v);
    logic signed [EB+1:0] sh, nsh;
    logic [WB-1:0]        lim, mag;
    logic                 clip;
    sh   = (EB+2)'($signed(v.e)) + (EB+2)'(FRAC_BITS);
    nsh  = -sh;
    lim  = v.neg ? (WB'(1) << (WORD_BITS - 1)) : (WB'(1) << (WORD_BITS - 1)) - WB'(1);
    clip = 1'b0;
    mag  = '0;
    if (v.m == '0) begin
      mag = '0;
    end else if (sh >= (EB+2)'(SH_CLIP)) begin
      mag  = lim;
      clip = 1'b1;
    end else begin
      if (sh >= 0) mag = WB'(v.m) << sh[1:0];
      else if (nsh > (EB+2)'(WB - 1)) mag = '0;
      else mag = WB'(v.m) >> nsh[5:0];
      if (mag > lim) begin
        mag  = lim;
        clip = 1'b1;
      end
    end
    return {clip, v.neg ? WORD_BITS'(-mag) : WORD_BITS'(mag)};
  endfunction

  logic                  adv;
  logic [MSB-1:0]        mass_ratio_r;
  rtbd_pkg::xf_t         mu_r, onem_r;
  rtbd_pkg::xf_t         px_r, py_r, pz_r, vx_r, vy_r;
  logic [3*WORD_BITS-1:0] vel_r, vel_d;
  logic [T9-1:0]         vld_r;
  logic                  out_v_r;

  rtbd_pkg::xf_t d1, d2, yy, zz, ax0, ay0, q, dd1, dd2, s1, s2;
  rtbd_pkg::xf_t s1_d, s2_d, rt1, rt2, p1, p2, g1, g2;
  rtbd_pkg::xf_t d1_d, d2_d, py_d, pz_d, ax0_d, ay0_d;
  rtbd_pkg::xf_t t1x, t2x, t1y, t2y, t1z, t2z, t2x_d, t2y_d;
  rtbd_pkg::xf_t ax1, ay1, az, az_d, ax, ay;
  logic [1:0]            sing_d;
  logic [WORD_BITS:0]    ox, oy, oz;

  logic [WORD_BITS-1:0]  rate_x_r, rate_y_r, rate_z_r, acc_x_r, acc_y_r, acc_z_r;
  logic                  sat_r, sing_r;

  assign adv           = !out_v_r || out_item.ready;
  assign in_item.ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_ratio_r <= rtbd_pkg::MASS_RESET;
    end else if (cfg_wr_en) begin
      mass_ratio_r <= cfg_wr_data;
    end
  end

  // mass terms follow the register every cycle
  always_ff @(posedge clk) begin
    mu_r   <= rtbd_pkg::xf_norm(1'b0, WB'(mass_ratio_r), E_MASS);
    onem_r <= rtbd_pkg::xf_norm(1'b0, WB'((MSB+1)'(1) << MSB) - WB'(mass_ratio_r), E_MASS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r  <= to_xf(in_item.pos_x);
      py_r  <= to_xf(in_item.pos_y);
      pz_r  <= to_xf(in_item.pos_z);
      vx_r  <= to_xf(in_item.vel_x);
      vy_r  <= to_xf(in_item.vel_y);
      vel_r <= {in_item.vel_z, in_item.vel_y, in_item.vel_x};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      vld_r   <= {vld_r[T9-2:0], in_item.valid};
      out_v_r <= vld_r[T9-1];
    end
  end

  // offsets, distances squared, rotating-frame acceleration terms
  rtbd_fadd u_d1  (.clk, .en(adv), .a(px_r), .b(mu_r), .y(d1));
  rtbd_fadd u_d2  (.clk, .en(adv), .a(px_r), .b(rtbd_pkg::xf_neg(onem_r)), .y(d2));
  rtbd_fmul u_yy  (.clk, .en(adv), .a(py_r), .b(py_r), .y(yy));
  rtbd_fmul u_zz  (.clk, .en(adv), .a(pz_r), .b(pz_r), .y(zz));
  rtbd_fadd u_ax0 (.clk, .en(adv), .a(rtbd_pkg::xf_dbl(vy_r)), .b(px_r), .y(ax0));
  rtbd_fadd u_ay0 (.clk, .en(adv), .a(rtbd_pkg::xf_neg(rtbd_pkg::xf_dbl(vx_r))), .b(py_r),
                   .y(ay0));
  rtbd_fadd u_q   (.clk, .en(adv), .a(yy), .b(zz), .y(q));
  rtbd_fmul u_dd1 (.clk, .en(adv), .a(d1), .b(d1), .y(dd1));
  rtbd_fmul u_dd2 (.clk, .en(adv), .a(d2), .b(d2), .y(dd2));
  rtbd_fadd u_s1  (.clk, .en(adv), .a(dd1), .b(q), .y(s1));
  rtbd_fadd u_s2  (.clk, .en(adv), .a(dd2), .b(q), .y(s2));

  // pulls of the two primaries
  rtbd_fsqrt u_rt1 (.clk, .en(adv), .a(s1), .y(rt1));
  rtbd_fsqrt u_rt2 (.clk, .en(adv), .a(s2), .y(rt2));
  rtbd_delay #(.WIDTH(XB), .DEPTH(rtbd_pkg::LAT_SQRT)) u_s1_dl (.clk, .en(adv), .d(s1), .q(s1_d));
  rtbd_delay #(.WIDTH(XB), .DEPTH(rtbd_pkg::LAT_SQRT)) u_s2_dl (.clk, .en(adv), .d(s2), .q(s2_d));
  rtbd_fmul u_p1 (.clk, .en(adv), .a(s1_d), .b(rt1), .y(p1));
  rtbd_fmul u_p2 (.clk, .en(adv), .a(s2_d), .b(rt2), .y(p2));
  rtbd_fdiv u_g1 (.clk, .en(adv), .a(onem_r), .b(p1), .y(g1));
  rtbd_fdiv u_g2 (.clk, .en(adv), .a(mu_r), .b(p2), .y(g2));

  rtbd_delay #(.WIDTH(XB), .DEPTH(T6 - T1)) u_d1_dl (.clk, .en(adv), .d(d1), .q(d1_d));
  rtbd_delay #(.WIDTH(XB), .DEPTH(T6 - T1)) u_d2_dl (.clk, .en(adv), .d(d2), .q(d2_d));
  rtbd_delay #(.WIDTH(XB), .DEPTH(T6 - T0)) u_py_dl (.clk, .en(adv), .d(py_r), .q(py_d));
  rtbd_delay #(.WIDTH(XB), .DEPTH(T6 - T0)) u_pz_dl (.clk, .en(adv), .d(pz_r), .q(pz_d));

  rtbd_fmul u_t1x (.clk, .en(adv), .a(d1_d), .b(g1), .y(t1x));
  rtbd_fmul u_t2x (.clk, .en(adv), .a(d2_d), .b(g2), .y(t2x));
  rtbd_fmul u_t1y (.clk, .en(adv), .a(py_d), .b(g1), .y(t1y));
  rtbd_fmul u_t2y (.clk, .en(adv), .a(py_d), .b(g2), .y(t2y));
  rtbd_fmul u_t1z (.clk, .en(adv), .a(pz_d), .b(g1), .y(t1z));
  rtbd_fmul u_t2z (.clk, .en(adv), .a(pz_d), .b(g2), .y(t2z));

  // accumulate accelerations
  rtbd_delay #(.WIDTH(XB), .DEPTH(T7 - T1)) u_ax0_dl (.clk, .en(adv), .d(ax0), .q(ax0_d));
  rtbd_delay #(.WIDTH(XB), .DEPTH(T7 - T1)) u_ay0_dl (.clk, .en(adv), .d(ay0), .q(ay0_d));
  rtbd_fadd u_ax1 (.clk, .en(adv), .a(ax0_d), .b(rtbd_pkg::xf_neg(t1x)), .y(ax1));
  rtbd_fadd u_ay1 (.clk, .en(adv), .a(ay0_d), .b(rtbd_pkg::xf_neg(t1y)), .y(ay1));
  rtbd_fadd u_az  (.clk, .en(adv), .a(rtbd_pkg::xf_neg(t1z)), .b(rtbd_pkg::xf_neg(t2z)),
                   .y(az));
  rtbd_delay #(.WIDTH(XB), .DEPTH(LA)) u_t2x_dl (.clk, .en(adv), .d(t2x), .q(t2x_d));
  rtbd_delay #(.WIDTH(XB), .DEPTH(LA)) u_t2y_dl (.clk, .en(adv), .d(t2y), .q(t2y_d));
  rtbd_delay #(.WIDTH(XB), .DEPTH(LA)) u_az_dl  (.clk, .en(adv), .d(az), .q(az_d));
  rtbd_fadd u_ax (.clk, .en(adv), .a(ax1), .b(rtbd_pkg::xf_neg(t2x_d)), .y(ax));
  rtbd_fadd u_ay (.clk, .en(adv), .a(ay1), .b(rtbd_pkg::xf_neg(t2y_d)), .y(ay));

  rtbd_delay #(.WIDTH(3 * WORD_BITS), .DEPTH(T9 - T0)) u_vel_dl (
    .clk, .en(adv), .d(vel_r), .q(vel_d)
  );
  rtbd_delay #(.WIDTH(2), .DEPTH(T9 - T3)) u_sing_dl (
    .clk, .en(adv), .d({s2.m == '0, s1.m == '0}), .q(sing_d)
  );

  assign ox = xf_out(ax);
  assign oy = xf_out(ay);
  assign oz = xf_out(az_d);

  always_ff @(posedge clk) begin
    if (adv) begin
      rate_x_r <= vel_d[WORD_BITS-1:0];
      rate_y_r <= vel_d[2*WORD_BITS-1:WORD_BITS];
      rate_z_r <= vel_d[3*WORD_BITS-1:2*WORD_BITS];
      acc_x_r  <= ox[WORD_BITS-1:0];
      acc_y_r  <= oy[WORD_BITS-1:0];
      acc_z_r  <= oz[WORD_BITS-1:0];
      sat_r    <= ox[WORD_BITS] | oy[WORD_BITS] | oz[WORD_BITS];
      sing_r   <= |sing_d;
    end
  end

  assign out_item.valid     = out_v_r;
  assign out_item.rate_x    = rate_x_r;
  assign out_item.rate_y    = rate_y_r;
  assign out_item.rate_z    = rate_z_r;
  assign out_item.acc_x     = acc_x_r;
  assign out_item.acc_y     = acc_y_r;
  assign out_item.acc_z     = acc_z_r;
  assign out_item.saturated = sat_r;
  assign out_item.singular  = sing_r;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && !out_item.ready |-> !in_item.ready)
    else $error("input taken while output stalled");

  a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.valid && in_item.ready |=> vld_r[0])
    else $error("accepted transaction lost its valid bit");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(vld_r[T9-1]))
    else $error("result appeared without a transaction in the pipe");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && sat_r |-> acc_x_r == ACC_MAX || acc_x_r == ACC_MIN ||
                         acc_y_r == ACC_MAX || acc_y_r == ACC_MIN ||
                         acc_z_r == ACC_MAX || acc_z_r == ACC_MIN)
    else $error("saturation flag without a clipped acceleration");
endmodule

FILE: tb/tb_restricted_three_body_derivative.sv
`timescale 1ns / 100ps
// tb_restricted_three_body_derivative: checks the three-body derivative pipeline
// against its own bit-exact model of the internal number format; random idling
// on both channels; depends on rtbd_pkg, rtbd_if and the top level
module tb_restricted_three_body_derivative;

  localparam int W = rtbd_pkg::WORD_BITS_DEF;
  localparam int FB = rtbd_pkg::FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN = 200;

  typedef struct {
    logic [W-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  } state_t;

  typedef struct packed {
    logic [W-1:0] rate_x, rate_y, rate_z, acc_x, acc_y, acc_z;
    logic         saturated, singular;
  } deriv_t;

  typedef struct {
    bit          neg;
    logic [63:0] m;
    int          e;
  } num_t;

  class deriv_scoreboard;
    deriv_t     pending[$];
    logic [31:0] mass;
    int         errs;
    int         n_in;

    function new();
      mass = rtbd_pkg::MASS_RESET;
      errs = 0;
      n_in = 0;
    endfunction

    function num_t mk(bit neg, logic [63:0] m, int e);
      num_t r;
      r.neg = 0; r.m = 0; r.e = 0;
      if (m == 0) return r;
      while (m >= 64'h4000_0000_0000_0000) begin
        m = m >> 1;
        e++;
      end
      while (m < 64'h2000_0000_0000_0000) begin
        m = m << 1;
        e--;
      end
      r.neg = neg; r.m = m; r.e = e;
      return r;
    endfunction

    function num_t from_word(logic [W-1:0] w);
      logic [W-1:0] t;
      t = -w;
      if (w[W-1]) return mk(1, 64'(t), -FB);
      return mk(0, 64'(w), -FB);
    endfunction

    function num_t negate(num_t a);
      if (a.m != 0) a.neg = !a.neg;
      return a;
    endfunction

    function num_t twice(num_t a);
      if (a.m != 0) a.e += 1;
      return a;
    endfunction

    function num_t sum(num_t a, num_t b);
      num_t t;
      int d;
      logic [63:0] bm;
      if (a.m == 0) return b;
      if (b.m == 0) return a;
      if (b.e > a.e) begin
        t = a; a = b; b = t;
      end
      d = a.e - b.e;
      bm = (d > 63) ? 64'd0 : (b.m >> d);
      if (a.neg == b.neg) return mk(a.neg, a.m + bm, a.e);
      if (a.m >= bm) return mk(a.neg, a.m - bm, a.e);
      return mk(b.neg, bm - a.m, a.e);
    endfunction

    function num_t prod(num_t a, num_t b);
      logic [127:0] p;
      if (a.m == 0 || b.m == 0) return mk(0, 0, 0);
      p = {64'd0, a.m} * {64'd0, b.m};
      p = p >> 62;
      return mk(a.neg ^ b.neg, p[63:0], a.e + b.e + 62);
    endfunction

    function num_t quot(num_t a, num_t b);
      logic [127:0] n;
      if (a.m == 0 || b.m == 0) return mk(0, 0, 0);
      n = ({64'd0, a.m} << 62) / {64'd0, b.m};
      return mk(a.neg ^ b.neg, n[63:0], a.e - b.e - 62);
    endfunction

    function num_t root(num_t a);
      logic [127:0] n, sq;
      logic [63:0]  r, trial;
      logic [63:0]  m;
      int           e;
      if (a.m == 0) return mk(0, 0, 0);
      m = a.m;
      e = a.e;
      if (e % 2 != 0) begin
        m = m << 1;
        e -= 1;
      end
      n = {64'd0, m} << 60;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        trial = r | (64'd1 << i);
        sq = {64'd0, trial} * {64'd0, trial};
        if (sq <= n) r = trial;
      end
      return mk(0, r, (e - 60) / 2);
    endfunction

    function logic [W-1:0] to_word(num_t v, inout bit clip);
      logic [63:0] mag, lim;
      int sh;
      if (v.m == 0) return '0;
      sh = v.e + FB;
      lim = v.neg ? (64'd1 << (W - 1)) : (64'd1 << (W - 1)) - 1;
      if (sh >= 3) begin
        mag = lim;
        clip = 1;
      end else begin
        if (sh >= 0) mag = v.m << sh;
        else mag = (-sh > 63) ? 64'd0 : (v.m >> (-sh));
        if (mag > lim) begin
          mag = lim;
          clip = 1;
        end
      end
      mag = v.neg ? -mag : mag;
      return mag[W-1:0];
    endfunction

    function num_t gravity(num_t gm, num_t s, inout bit sing);
      if (s.m == 0) begin
        sing = 1;
        return mk(0, 0, 0);
      end
      return quot(gm, prod(s, root(s)));
    endfunction

    function deriv_t derive(state_t s);
      num_t px, py, pz, vx, vy, mu, onem, d1, d2, q, s1, s2, g1, g2, ax, ay, az;
      bit sing, clip;
      deriv_t r;
      px = from_word(s.pos_x);
      py = from_word(s.pos_y);
      pz = from_word(s.pos_z);
      vx = from_word(s.vel_x);
      vy = from_word(s.vel_y);
      mu = mk(0, 64'(mass), -32);
      onem = mk(0, 64'h1_0000_0000 - 64'(mass), -32);
      d1 = sum(px, mu);
      d2 = sum(px, negate(onem));
      q = sum(prod(py, py), prod(pz, pz));
      s1 = sum(prod(d1, d1), q);
      s2 = sum(prod(d2, d2), q);
      sing = 0;
      clip = 0;
      g1 = gravity(onem, s1, sing);
      g2 = gravity(mu, s2, sing);
      ax = sum(twice(vy), px);
      ax = sum(ax, negate(prod(d1, g1)));
      ax = sum(ax, negate(prod(d2, g2)));
      ay = sum(negate(twice(vx)), py);
      ay = sum(ay, negate(prod(py, g1)));
      ay = sum(ay, negate(prod(py, g2)));
      az = sum(negate(prod(pz, g1)), negate(prod(pz, g2)));
      r.rate_x = s.vel_x;
      r.rate_y = s.vel_y;
      r.rate_z = s.vel_z;
      r.acc_x = to_word(ax, clip);
      r.acc_y = to_word(ay, clip);
      r.acc_z = to_word(az, clip);
      r.saturated = clip;
      r.singular = sing;
      return r;
    endfunction

    function void note_state(state_t s);
      pending = {pending, derive(s)};
      n_in++;
    endfunction

    function void check_deriv(deriv_t got);
      deriv_t exp_d;
      if (pending.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result transaction at %0t", $realtime);
        return;
      end
      exp_d = pending.pop_front();
      if (got !== exp_d) begin
        errs++;
        if (errs <= 10)
          $display("mismatch at %0t: exp rate %h %h %h acc %h %h %h sat %b sing %b, ",
                   $realtime, exp_d.rate_x, exp_d.rate_y, exp_d.rate_z, exp_d.acc_x,
                   exp_d.acc_y, exp_d.acc_z, exp_d.saturated, exp_d.singular,
                   "got rate %h %h %h acc %h %h %h sat %b sing %b",
                   got.rate_x, got.rate_y, got.rate_z, got.acc_x, got.acc_y, got.acc_z,
                   got.saturated, got.singular);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  bit          pressed;
  bit          holding;
  int          quiet;

  rtbd_in_if  in_if ();
  rtbd_out_if out_if ();

  deriv_scoreboard sb = new();

  restricted_three_body_derivative DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_if),
    .out_item    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [W-1:0] rnd_word();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    return t[W-1:0];
  endfunction

  // signed value in the range -2^bits to 2^bits - 1
  function automatic logic [W-1:0] rnd_span(int bits);
    logic signed [W-1:0] v;
    v = rnd_word();
    return v >>> (W - 1 - bits);
  endfunction

  task automatic send_state(state_t s);
    int gap;
    in_if.valid <= 1'b1;
    in_if.pos_x <= s.pos_x;
    in_if.pos_y <= s.pos_y;
    in_if.pos_z <= s.pos_z;
    in_if.vel_x <= s.vel_x;
    in_if.vel_y <= s.vel_y;
    in_if.vel_z <= s.vel_z;
    do @(posedge clk); while (!in_if.ready);
    // keep offering while the receiver holds off
    gap = holding ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_mass(logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.mass = v;
  endtask

  task automatic run_phase(logic [31:0] mr, int n, bit directed);
    state_t s;
    logic [W-1:0] c1, c2;
    int kind;
    write_mass(mr);
    c1 = W'(0) - W'(mr);
    c2 = W'(64'h1_0000_0000) - W'(mr);
    // zero distance to each primary, then just off it
    s = '{c1, 0, 0, 0, 0, 0};
    send_state(s);
    s = '{c2, 0, 0, rnd_word(), rnd_word(), rnd_word()};
    send_state(s);
    s = '{c1 + 1, 0, 0, 0, 0, 0};
    send_state(s);
    s = '{c2, 0, 1, 0, 0, 0};
    send_state(s);
    if (directed) begin
      s = '{0, 0, 0, 0, 0, 0};
      send_state(s);
      s = '{{1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}},
            {1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}}};
      send_state(s);
      s = '{{1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}},
            {1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}}};
      send_state(s);
      s = '{{1'b1, {(W-1){1'b0}}}, 0, 0, {1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}}, 0};
      send_state(s);
      s = '{W'(64'h8000_0000), W'(64'h7000_0000), 0, W'(-64'h1_0000_0000), 0, 1};
      send_state(s);
      s = '{c1, W'(1), 0, W'(-1), W'(1), W'(-1)};
      send_state(s);
      s = '{c2 - 1, 0, W'(-1), W'(64'h2_0000_0000), W'(-64'h3_0000_0000), 0};
      send_state(s);
      s = '{W'(64'h20_0000_0000), W'(-64'h20_0000_0000), W'(64'h10_0000_0000), 0, 0, 0};
      send_state(s);
    end
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        s = '{rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word()};
      end else if (kind < 5) begin
        s.pos_x = ($urandom_range(0, 1) ? c1 : c2) + rnd_span($urandom_range(0, 30));
        s.pos_y = rnd_span($urandom_range(0, 30));
        s.pos_z = $urandom_range(0, 3) == 0 ? W'(0) : rnd_span($urandom_range(0, 30));
        s.vel_x = rnd_span($urandom_range(0, 35));
        s.vel_y = rnd_span($urandom_range(0, 35));
        s.vel_z = rnd_span($urandom_range(0, 35));
      end else begin
        s.pos_x = rnd_span($urandom_range(28, 34));
        s.pos_y = rnd_span($urandom_range(20, 34));
        s.pos_z = rnd_span($urandom_range(16, 33));
        s.vel_x = rnd_span($urandom_range(20, 35));
        s.vel_y = rnd_span($urandom_range(20, 35));
        s.vel_z = rnd_span($urandom_range(20, 35));
      end
      send_state(s);
    end
    go_idle();
  endtask

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_state('{in_if.pos_x, in_if.pos_y, in_if.pos_z,
                      in_if.vel_x, in_if.vel_y, in_if.vel_z});
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_deriv('{out_if.rate_x, out_if.rate_y, out_if.rate_z, out_if.acc_x,
                       out_if.acc_y, out_if.acc_z, out_if.saturated, out_if.singular});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet > STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side back-pressure, with one long hold-off to fill the pipeline
  initial begin
    out_if.ready <= 1'b0;
    pressed = 0;
    holding = 0;
    @(posedge clk);
    forever begin
      if (!pressed && sb.n_in >= 40) begin
        pressed = 1;
        holding = 1;
        out_if.ready <= 1'b0;
        repeat (500) @(posedge clk);
        holding = 0;
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if ($urandom_range(0, 2) == 0) begin
          out_if.ready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_if.valid <= 1'b0;
    in_if.pos_x <= '0;
    in_if.pos_y <= '0;
    in_if.pos_z <= '0;
    in_if.vel_x <= '0;
    in_if.vel_y <= '0;
    in_if.vel_z <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_phase(rtbd_pkg::MASS_RESET, 0, 1);
    run_phase(32'h0000_3262, 260, 0);
    run_phase(32'h0000_0000, 130, 1);
    run_phase(32'h8000_0000, 70, 0);
    run_phase(32'hFFFF_FFFF, 100, 1);
    run_phase($urandom_range(1, 32'h8000_0000), 60, 0);
    run_phase(32'h0000_0001, 30, 0);
    if (sb.errs == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: restricted_three_body_derivative.f
hw/rtl/rtbd_pkg.sv
hw/rtl/rtbd_if.sv
hw/rtl/rtbd_delay.sv
hw/rtl/rtbd_fadd.sv
hw/rtl/rtbd_fmul.sv
hw/rtl/rtbd_fsqrt.sv
hw/rtl/rtbd_fdiv.sv
hw/rtl/restricted_three_body_derivative.sv
tb/tb_restricted_three_body_derivative.sv
